// ----- rtl/core/assert_macros.svh -----
// Assertion macros of the decoder RTL, used by pcx_datapath.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCX_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCX_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pcx_pkg.sv -----
// Types and constants of the PCX run-length decoder.
// No dependencies; used by every RTL module and interface of the block.
`default_nettype none

package pcx_pkg;

    localparam int BYTE_W   = 8;
    localparam int DIM_W    = 13;
    localparam int STRIDE_W = 14;
    localparam int ADDR_W   = 24;
    localparam int RUN_W    = 6;
    localparam int IDX_W    = 1;

    localparam logic [BYTE_W-1:0] RUN_TAG  = 8'hC0;
    localparam logic [BYTE_W-1:0] RUN_MASK = 8'h3F;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic accept;
        logic emit;
    } pcx_cmd_t;

    typedef struct packed {
        logic start_run;
        logic slot_free;
        logic run_last;
    } pcx_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/pcx_code_if.sv -----
// Channel of encoded code bytes.
// Depends on pcx_pkg.
`default_nettype none

interface pcx_code_if;
    import pcx_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink   (input valid, input code_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pcx_pixel_if.sv -----
// Channel of decoded pixel words.
// Depends on pcx_pkg.
`default_nettype none

interface pcx_pixel_if;
    import pcx_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel_value;
    logic [ADDR_W-1:0] pixel_address;
    logic              run_last;
    logic              image_done;

    modport source (output valid, output pixel_value, output pixel_address,
                    output run_last, output image_done, input ready);
    modport sink   (input valid, input pixel_value, input pixel_address,
                    input run_last, input image_done, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pcx_cfg_if.sv -----
// Configuration write channel: register index and write data.
// Depends on pcx_pkg.
`default_nettype none

interface pcx_cfg_if;
    import pcx_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [DIM_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pcx_rle_decoder.sv -----
// A literal goes to the value register; the emit state then loads the output word register.
// A run marker sets n; its value byte starts a run of up to n pixels, cut short at a row end,
// one pixel per cycle from the emit sequencer, unless output stalls; no byte is taken mid-run.
// Reset: asynchronous, active low; position to row 0 column 0, width and height to 1.
// Files: pcx_rle_decoder top level; controller pcx_ctrl and datapath pcx_datapath.
// Depends on pcx_pkg, pcx_code_if, pcx_pixel_if, pcx_cfg_if.
`default_nettype none

module pcx_rle_decoder #(
    parameter int MAX_DIM   = 4096,
    parameter int ROW_ALIGN = 4
) (
    input  wire         clk,
    input  wire         rst_n,
    pcx_code_if.sink    code,
    pcx_pixel_if.source pixel,
    pcx_cfg_if.sink     cfg
);
    import pcx_pkg::*;

    pcx_cmd_t    cmd;
    pcx_status_t status;

    pcx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (code.valid),
        .in_ready (code.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pcx_datapath #(
        .MAX_DIM   (MAX_DIM),
        .ROW_ALIGN (ROW_ALIGN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .code_byte (code.code_byte),
        .cmd       (cmd),
        .status    (status),
        .cfg       (cfg),
        .pixel     (pixel)
    );

endmodule

`default_nettype wire

// ----- rtl/core/pcx_ctrl.sv -----
// Controller of the decoder: accepts code bytes and sequences pixel output.
// Depends on pcx_pkg.
`default_nettype none

module pcx_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  pcx_pkg::pcx_status_t status,
    output pcx_pkg::pcx_cmd_t    cmd
);
    import pcx_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd.accept = (state_reg == ST_IDLE) && in_valid;
        cmd.emit   = (state_reg == ST_EMIT) && status.slot_free;
        in_ready   = (state_reg == ST_IDLE);
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && status.start_run)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.emit && status.run_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pcx_datapath.sv -----
// Datapath of the decoder: configuration, decode state, position and pixel output word.
// Depends on pcx_pkg, pcx_cfg_if, pcx_pixel_if and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module pcx_datapath #(
    parameter int MAX_DIM   = 4096,
    parameter int ROW_ALIGN = 4
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire [pcx_pkg::BYTE_W-1:0] code_byte,
    input  pcx_pkg::pcx_cmd_t        cmd,
    output pcx_pkg::pcx_status_t     status,
    pcx_cfg_if.sink                  cfg,
    pcx_pixel_if.source              pixel
);
    import pcx_pkg::*;

    localparam int DIM_MAX   = (1 << DIM_W) - 1;
    localparam int CLAMP_MAX = (MAX_DIM > DIM_MAX) ? DIM_MAX : MAX_DIM;
    localparam int RECIP_SH  = 17;
    localparam int RECIP     = ((1 << RECIP_SH) + ROW_ALIGN - 1) / ROW_ALIGN;
    localparam int PROD_W    = 32;

    logic [DIM_W-1:0]    width_reg,  width_next;
    logic [DIM_W-1:0]    height_reg, height_next;
    logic [STRIDE_W-1:0] stride_reg, stride_next;
    logic                await_reg,  await_next;
    logic [RUN_W-1:0]    count_reg,  count_next;
    logic [RUN_W-1:0]    rem_reg,    rem_next;
    logic [BYTE_W-1:0]   value_reg,  value_next;
    logic [DIM_W-1:0]    column_reg, column_next;
    logic [DIM_W-1:0]    row_reg,    row_next;
    logic [ADDR_W-1:0]   base_reg,   base_next;
    logic                ovalid_reg, ovalid_next;
    logic [BYTE_W-1:0]   opix_reg;
    logic [ADDR_W-1:0]   oaddr_reg;
    logic                olast_reg;
    logic                odone_reg;

    logic [DIM_W-1:0]    cfg_dim;
    logic [STRIDE_W-1:0] cfg_round;
    logic [PROD_W-1:0]   cfg_prod;
    logic [STRIDE_W-1:0] cfg_stride;
    logic                full;
    logic                marker;
    logic                row_end;
    logic                px_done;
    logic                px_last;
    logic [ADDR_W-1:0]   px_addr;

    always_comb
    begin
        if (cfg.data == '0)
        begin
            cfg_dim = DIM_W'(1);
        end
        else if ({1'b0, cfg.data} > (DIM_W + 1)'(CLAMP_MAX))
        begin
            cfg_dim = DIM_W'(CLAMP_MAX);
        end
        else
        begin
            cfg_dim = cfg.data;
        end
        cfg_round  = STRIDE_W'(cfg_dim) + STRIDE_W'(ROW_ALIGN - 1);
        cfg_prod   = PROD_W'(cfg_round) * PROD_W'(RECIP);
        cfg_stride = STRIDE_W'(cfg_prod[RECIP_SH +: STRIDE_W] * STRIDE_W'(ROW_ALIGN));
    end

    assign full    = (row_reg >= height_reg);
    assign marker  = ((code_byte & RUN_TAG) == RUN_TAG);
    assign row_end = ((STRIDE_W'(column_reg) + STRIDE_W'(1)) >= STRIDE_W'(width_reg));
    assign px_done = row_end && ((STRIDE_W'(row_reg) + STRIDE_W'(1)) >= STRIDE_W'(height_reg));
    assign px_last = (rem_reg == RUN_W'(1)) || row_end;
    assign px_addr = base_reg + ADDR_W'(column_reg);

    always_comb
    begin
        status.start_run = !full && (await_reg ? (count_reg != '0) : !marker);
        status.slot_free = !ovalid_reg || pixel.ready;
        status.run_last  = px_last;
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        stride_next = stride_reg;
        await_next  = await_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        value_next  = value_reg;
        column_next = column_reg;
        row_next    = row_reg;
        base_next   = base_reg;
        ovalid_next = ovalid_reg && !pixel.ready;

        if (cfg.valid)
        begin
            case (cfg.index)
                REG_IMAGE_WIDTH:
                begin
                    width_next  = cfg_dim;
                    stride_next = cfg_stride;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_next = cfg_dim;
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
        end

        if (cmd.accept && !full)
        begin
            if (await_reg)
            begin
                await_next = 1'b0;
                count_next = '0;
                rem_next   = count_reg;
                value_next = code_byte;
            end
            else if (marker)
            begin
                await_next = 1'b1;
                count_next = RUN_W'(code_byte & RUN_MASK);
            end
            else
            begin
                rem_next   = RUN_W'(1);
                value_next = code_byte;
            end
        end

        if (cmd.emit)
        begin
            ovalid_next = 1'b1;
            rem_next    = rem_reg - RUN_W'(1);
            if (row_end)
            begin
                column_next = '0;
                row_next    = row_reg + DIM_W'(1);
                base_next   = base_reg + ADDR_W'(stride_reg);
            end
            else
            begin
                column_next = column_reg + DIM_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            stride_reg <= STRIDE_W'(ROW_ALIGN);
            await_reg  <= 1'b0;
            count_reg  <= '0;
            rem_reg    <= '0;
            column_reg <= '0;
            row_reg    <= '0;
            base_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            stride_reg <= stride_next;
            await_reg  <= await_next;
            count_reg  <= count_next;
            rem_reg    <= rem_next;
            column_reg <= column_next;
            row_reg    <= row_next;
            base_reg   <= base_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (cmd.emit)
        begin
            opix_reg  <= value_reg;
            oaddr_reg <= px_addr;
            olast_reg <= px_last;
            odone_reg <= px_done;
        end
    end

    assign cfg.ready           = 1'b1;
    assign pixel.valid         = ovalid_reg;
    assign pixel.pixel_value   = opix_reg;
    assign pixel.pixel_address = oaddr_reg;
    assign pixel.run_last      = olast_reg;
    assign pixel.image_done    = odone_reg;

    `PCX_ASSERT_IMP(a_emit_has_rem, clk, rst_n, cmd.emit, rem_reg != '0, "emit with no pixels left")
    `PCX_ASSERT_NXT(a_start_loads_rem, clk, rst_n, cmd.accept && status.start_run, rem_reg != '0, "run started empty")
    `PCX_ASSERT_NXT(a_emit_fills_slot, clk, rst_n, cmd.emit, ovalid_reg, "emitted word lost")
    `PCX_ASSERT_NXT(a_more_left, clk, rst_n, cmd.emit && !px_last, rem_reg != '0, "run ended early")

endmodule

`default_nettype wire
